### sv/ddo_pkg.sv
// Types, codes and constants shared by the differential-drive odometry block.
// Holds the payload structs, the sequencer states and the CORDIC arctangent table.
// No dependencies.
package ddo_pkg;

  typedef struct packed {
    logic signed [15:0] left_wheel_speed;
    logic signed [15:0] right_wheel_speed;
  } in_t;

  typedef struct packed {
    logic signed [15:0] linear_velocity;
    logic signed [15:0] angular_velocity;
    logic signed [31:0] position_x;
    logic signed [31:0] position_y;
    logic        [15:0] heading_angle;
  } out_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MULA,
    S_DIST,
    S_DIVGO,
    S_DIVW,
    S_CORW,
    S_MULB,
    S_DONE
  } state_t;

  // Configuration register indexes.
  localparam logic [1:0] REG_WHEEL_RADIUS     = 2'd0;
  localparam logic [1:0] REG_WHEEL_SEPARATION = 2'd1;
  localparam logic [1:0] REG_PERIOD_MS        = 2'd2;

  localparam logic [15:0] RST_WHEEL_RADIUS     = 16'd3277;
  localparam logic [15:0] RST_WHEEL_SEPARATION = 16'd16384;
  localparam logic [9:0]  RST_PERIOD_MS        = 10'd10;

  // Multiplier sequence steps.
  localparam logic [3:0] MS_PV    = 4'd0;
  localparam logic [3:0] MS_PW    = 4'd1;
  localparam logic [3:0] MS_SP    = 4'd2;
  localparam logic [3:0] MS_DM    = 4'd3;
  localparam logic [3:0] MS_DP    = 4'd4;
  localparam logic [3:0] MS_AM    = 4'd5;
  localparam logic [3:0] MS_A_END = 4'd6;
  localparam logic [3:0] MS_XL    = 4'd6;
  localparam logic [3:0] MS_XH    = 4'd7;
  localparam logic [3:0] MS_YL    = 4'd8;
  localparam logic [3:0] MS_YH    = 4'd9;
  localparam logic [3:0] MS_HL    = 4'd10;
  localparam logic [3:0] MS_HH    = 4'd11;
  localparam logic [3:0] MS_B_END = 4'd12;

  // Divider jobs.
  localparam logic [1:0] DIV_W    = 2'd0;
  localparam logic [1:0] DIV_ANG  = 2'd1;

  localparam int DIV_NUM_W = 52;
  localparam int DIV_DEN_W = 26;
  localparam int DIV_CNT_W = 6;

  // The division by 1000 runs over four 16-bit digits. Each digit is a multiply by
  // ceil(2^36/1000) and a shift by 36, which is exact for dividends below 1000*2^16.
  localparam logic [31:0] DIST_RECIP = 32'd68719477;
  localparam logic [2:0]  DIST_LAST  = 3'd7;

  localparam int TABLE_LEN = 24;
  localparam int STEP_W    = 5;
  localparam logic signed [31:0] CORDIC_START   = 32'sd652032874;
  localparam logic [31:0]        INV_TWO_PI_Q32 = 32'd683565276;

  function automatic logic [31:0] atan_val(input logic [STEP_W-1:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051E;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2FA;
      5'd15: v = 32'h0000517D;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30;
      5'd19: v = 32'h00000518;
      5'd20: v = 32'h0000028C;
      5'd21: v = 32'h00000146;
      5'd22: v = 32'h000000A3;
      5'd23: v = 32'h00000051;
      default: v = 32'h0;
    endcase
    return v;
  endfunction

endpackage

### sv/ddo_mul.sv
// Shared 32x32 unsigned multiplier with a registered product.
// Depends on nothing beyond the clock.
module ddo_mul (
  input  logic        clk,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [63:0] prod
);

  logic [63:0] prod_r;

  always_ff @(posedge clk) begin
    prod_r <= {32'b0, a} * {32'b0, b};
  end

  assign prod = prod_r;

endmodule

### sv/ddo_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on ddo_pkg for the operand widths.
module ddo_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [ddo_pkg::DIV_NUM_W-1:0] num,
  input  logic [ddo_pkg::DIV_DEN_W-1:0] den,
  output logic                          done,
  output logic [ddo_pkg::DIV_NUM_W-1:0] quot
);
  import ddo_pkg::*;

  logic [DIV_NUM_W-1:0] num_r;
  logic [DIV_DEN_W-1:0] den_r;
  logic [DIV_DEN_W-1:0] rem_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 busy_r;
  logic                 done_r;
  logic [DIV_DEN_W:0]   shifted;
  logic [DIV_DEN_W:0]   trial;
  logic                 qbit;

  always_comb begin
    shifted = {rem_r, num_r[DIV_NUM_W-1]};
    trial   = shifted - {1'b0, den_r};
    qbit    = (shifted >= {1'b0, den_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == DIV_CNT_W'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= num;
      den_r <= den;
      rem_r <= '0;
      cnt_r <= DIV_CNT_W'(DIV_NUM_W);
    end else if (busy_r) begin
      num_r <= {num_r[DIV_NUM_W-2:0], qbit};
      rem_r <= qbit ? trial[DIV_DEN_W-1:0] : shifted[DIV_DEN_W-1:0];
      cnt_r <= cnt_r - DIV_CNT_W'(1);
    end
  end

  assign done = done_r;
  assign quot = num_r;

endmodule

### sv/ddo_cordic.sv
// Iterative rotation-mode CORDIC giving cos and sin of a binary angle.
// Depends on ddo_pkg for the arctangent table and the start value.
module ddo_cordic #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [15:0] angle,
  output logic        busy,
  output logic [17:0] cos_mag,
  output logic        cos_neg,
  output logic [17:0] sin_mag,
  output logic        sin_neg
);
  import ddo_pkg::*;

  localparam int STEPS = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;

  logic signed [31:0] x_r, y_r, z_r;
  logic [STEP_W-1:0]  i_r;
  logic               flip_r;
  logic               busy_r;
  logic               flip;
  logic signed [31:0] xs, ys;
  logic [31:0]        at;
  logic [31:0]        xabs, yabs;
  logic [32:0]        xrnd, yrnd;

  // Angles in the second and third quadrant are rotated by a half turn.
  assign flip = angle[15] ^ angle[14];

  always_comb begin
    xs   = x_r >>> i_r;
    ys   = y_r >>> i_r;
    at   = atan_val(i_r);
    xabs = x_r[31] ? 32'(-x_r) : 32'(x_r);
    yabs = y_r[31] ? 32'(-y_r) : 32'(y_r);
    xrnd = {1'b0, xabs} + 33'h2000;
    yrnd = {1'b0, yabs} + 33'h2000;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
    end else if (busy_r && i_r == STEP_W'(STEPS - 1)) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r    <= CORDIC_START;
      y_r    <= '0;
      z_r    <= {angle[15] ^ flip, angle[14:0], 16'b0};
      flip_r <= flip;
      i_r    <= '0;
    end else if (busy_r) begin
      if (!z_r[31]) begin
        x_r <= x_r - ys;
        y_r <= y_r + xs;
        z_r <= z_r - $signed(at);
      end else begin
        x_r <= x_r + ys;
        y_r <= y_r - xs;
        z_r <= z_r + $signed(at);
      end
      i_r <= i_r + STEP_W'(1);
    end
  end

  assign busy    = busy_r;
  assign cos_mag = xrnd[31:14];
  assign sin_mag = yrnd[31:14];
  assign cos_neg = x_r[31] ^ flip_r;
  assign sin_neg = y_r[31] ^ flip_r;

endmodule

### sv/diff_drive_odometry.sv
// Differential-drive dead-reckoning odometry: sequencer, pose state and output register.
// Depends on ddo_pkg, ddo_mul, ddo_div and ddo_cordic.
//
//   channel | ports                                | role
//   input   | in_valid, in_stall, in_data          | wheel speed request
//   output  | out_valid, out_stall, out_data       | velocities and updated pose
//   config  | cfg_wr_en, cfg_index, cfg_wdata      | register writes
//
// Requests are taken only in the idle state, one at a time; each then runs 7 multiplier
// steps, the division by 1000 as four reciprocal multiplies, two divisions on the shared
// divider (start, 52 quotient bits, done), one CORDIC check, 7 multiplier steps for the
// pose and the load of the result into the output register. The CORDIC runs from
// acceptance, alongside the multiplier steps.
// Reset (synchronous, rst_n low) clears the pose and loads the register defaults.
// A stalled result holds in the output register; the next request waits behind it.
module diff_drive_odometry #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  ddo_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output ddo_pkg::out_t out_data,
  input  logic          cfg_wr_en,
  input  logic [1:0]    cfg_index,
  input  logic [15:0]   cfg_wdata
);
  import ddo_pkg::*;

  state_t state_r, state_nxt;

  logic [15:0] radius_r, sep_r;
  logic [9:0]  period_r;
  logic [31:0] pose_x_r, pose_y_r;
  logic [15:0] pose_h_r;
  out_t        out_data_r;
  logic        out_valid_r;

  logic [15:0] r_r, d_r;
  logic [9:0]  p_r;
  logic        sum_neg_r, diff_neg_r;
  logic [16:0] sum_mag_r, diff_mag_r;
  logic [32:0] pv_mag_r, pw_mag_r;
  logic [42:0] dmul_r, amul_r;
  logic [33:0] w_q_r;
  logic [40:0] dist_mag_r;
  logic [47:0] ang_tc_r;
  logic [63:0] accx_r, accy_r;
  logic [47:0] acch_r;
  logic [3:0]  mstep_r;
  logic [1:0]  div_idx_r;
  logic [63:0] dnum_r;
  logic [9:0]  drem_r;
  logic [2:0]  dstep_r;

  logic        accept, out_free;
  logic [16:0] sum_s, diff_s;
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_prod;
  logic        div_start, div_done;
  logic [DIV_NUM_W-1:0] div_num, div_quot;
  logic [DIV_DEN_W-1:0] div_den, dk;
  logic        cor_busy, cos_neg, sin_neg;
  logic [17:0] cos_mag, sin_mag;
  logic [25:0] dsx, dsr;
  logic [15:0] dsq;

  logic [33:0] vsum;
  logic [16:0] vmag;
  logic [15:0] v_out, w_out;
  logic [63:0] xr, yr;
  logic [31:0] dx, dy;
  logic [47:0] hr;

  assign accept   = (state_r == S_IDLE) && in_valid;
  assign in_stall = (state_r != S_IDLE);
  assign out_free = !out_valid_r || !out_stall;

  assign sum_s  = {in_data.left_wheel_speed[15], in_data.left_wheel_speed}
                + {in_data.right_wheel_speed[15], in_data.right_wheel_speed};
  assign diff_s = {in_data.right_wheel_speed[15], in_data.right_wheel_speed}
                - {in_data.left_wheel_speed[15], in_data.left_wheel_speed};

  ddo_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (mul_prod)
  );

  ddo_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  ddo_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (accept),
    .angle   (pose_h_r),
    .busy    (cor_busy),
    .cos_mag (cos_mag),
    .cos_neg (cos_neg),
    .sin_mag (sin_mag),
    .sin_neg (sin_neg)
  );

  // One digit of the step distance divided by 1000: the remainder so far joined with
  // the next 16 bits, its quotient from the reciprocal product and the new remainder.
  assign dsx = {drem_r, dnum_r[63:48]};
  assign dsq = mul_prod[51:36];
  assign dsr = dsx - 26'(dsq) * 26'd1000;

  // Multiplier operand selection; the product is registered and appears in the next cycle.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state_r == S_DIST) begin
      mul_a = 32'(dsx);
      mul_b = DIST_RECIP;
    end else begin
      case (mstep_r)
        MS_PV: begin mul_a = 32'(r_r);        mul_b = 32'(sum_mag_r);  end
        MS_PW: begin mul_a = 32'(r_r);        mul_b = 32'(diff_mag_r); end
        MS_SP: begin mul_a = 32'(sum_mag_r);  mul_b = 32'(p_r);        end
        MS_DM: begin mul_a = mul_prod[31:0];  mul_b = 32'(r_r);        end
        MS_DP: begin mul_a = 32'(diff_mag_r); mul_b = 32'(p_r);        end
        MS_AM: begin mul_a = mul_prod[31:0];  mul_b = 32'(r_r);        end
        MS_XL: begin
          mul_a = (state_r == S_MULB) ? 32'(dist_mag_r[20:0]) : 32'd0;
          mul_b = 32'(cos_mag);
        end
        MS_XH: begin mul_a = 32'(dist_mag_r[40:21]); mul_b = 32'(cos_mag); end
        MS_YL: begin mul_a = 32'(dist_mag_r[20:0]);  mul_b = 32'(sin_mag); end
        MS_YH: begin mul_a = 32'(dist_mag_r[40:21]); mul_b = 32'(sin_mag); end
        MS_HL: begin mul_a = 32'(ang_tc_r[23:0]);    mul_b = INV_TWO_PI_Q32; end
        MS_HH: begin mul_a = 32'(ang_tc_r[47:24]);   mul_b = INV_TWO_PI_Q32; end
        default: begin mul_a = '0; mul_b = '0; end
      endcase
    end
  end

  assign dk = DIV_DEN_W'(d_r) * DIV_DEN_W'(1000);

  always_comb begin
    div_num = '0;
    div_den = '0;
    case (div_idx_r)
      DIV_W: begin
        div_num = DIV_NUM_W'(pw_mag_r) + DIV_NUM_W'(d_r[15:1]);
        div_den = DIV_DEN_W'(d_r);
      end
      DIV_ANG: begin
        div_num = DIV_NUM_W'({amul_r, 8'b0}) + DIV_NUM_W'(dk[DIV_DEN_W-1:1]);
        div_den = dk;
      end
      default: begin
        div_num = '0;
        div_den = '0;
      end
    endcase
  end

  assign div_start = (state_r == S_DIVGO);

  // Rounding: half away from zero, velocities saturate; the heading rounds half up.
  always_comb begin
    vsum = {1'b0, pv_mag_r} + 34'h1_0000;
    vmag = vsum[33:17];
    if (!sum_neg_r) begin
      v_out = (vmag > 17'd32767) ? 16'h7FFF : vmag[15:0];
    end else begin
      v_out = (vmag > 17'd32768) ? 16'h8000 : (~vmag[15:0] + 16'd1);
    end
    if (!diff_neg_r) begin
      w_out = (w_q_r > 34'd32767) ? 16'h7FFF : w_q_r[15:0];
    end else begin
      w_out = (w_q_r > 34'd32768) ? 16'h8000 : (~w_q_r[15:0] + 16'd1);
    end
    xr = accx_r + 64'h8000_0000;
    yr = accy_r + 64'h8000_0000;
    dx = (sum_neg_r ^ cos_neg) ? (~xr[63:32] + 32'd1) : xr[63:32];
    dy = (sum_neg_r ^ sin_neg) ? (~yr[63:32] + 32'd1) : yr[63:32];
    hr = acch_r + 48'h8000_0000;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_valid) state_nxt = S_MULA;
      S_MULA:  if (mstep_r == MS_A_END) state_nxt = S_DIST;
      S_DIST:  if (dstep_r == DIST_LAST) state_nxt = S_DIVGO;
      S_DIVGO: state_nxt = S_DIVW;
      S_DIVW: begin
        if (div_done) state_nxt = (div_idx_r == DIV_ANG) ? S_CORW : S_DIVGO;
      end
      S_CORW:  if (!cor_busy) state_nxt = S_MULB;
      S_MULB:  if (mstep_r == MS_B_END) state_nxt = S_DONE;
      S_DONE:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= RST_WHEEL_RADIUS;
      sep_r    <= RST_WHEEL_SEPARATION;
      period_r <= RST_PERIOD_MS;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_WHEEL_RADIUS:     radius_r <= cfg_wdata;
        REG_WHEEL_SEPARATION: sep_r    <= cfg_wdata;
        REG_PERIOD_MS:        period_r <= cfg_wdata[9:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pose_x_r    <= '0;
      pose_y_r    <= '0;
      pose_h_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      if (state_r == S_DONE && out_free) begin
        pose_x_r    <= pose_x_r + dx;
        pose_y_r    <= pose_y_r + dy;
        pose_h_r    <= pose_h_r + hr[47:32];
        out_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_DONE && out_free) begin
      out_data_r.linear_velocity  <= v_out;
      out_data_r.angular_velocity <= w_out;
      out_data_r.position_x       <= pose_x_r + dx;
      out_data_r.position_y       <= pose_y_r + dy;
      out_data_r.heading_angle    <= pose_h_r + hr[47:32];
    end
  end

  // Datapath registers for one request.
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          r_r        <= radius_r;
          d_r        <= (sep_r == 16'd0) ? 16'd1 : sep_r;
          p_r        <= period_r;
          sum_neg_r  <= sum_s[16];
          sum_mag_r  <= sum_s[16] ? (~sum_s + 17'd1) : sum_s;
          diff_neg_r <= diff_s[16];
          diff_mag_r <= diff_s[16] ? (~diff_s + 17'd1) : diff_s;
          mstep_r    <= MS_PV;
        end
      end
      S_MULA: begin
        mstep_r <= mstep_r + 4'd1;
        case (mstep_r)
          MS_PW:    pv_mag_r <= mul_prod[32:0];
          MS_SP:    pw_mag_r <= mul_prod[32:0];
          MS_DP:    dmul_r   <= mul_prod[42:0];
          MS_A_END: begin
            amul_r    <= mul_prod[42:0];
            div_idx_r <= DIV_W;
            dnum_r    <= 64'({dmul_r, 7'b0}) + 64'd500;
            drem_r    <= '0;
            dstep_r   <= '0;
          end
          default: ;
        endcase
      end
      S_DIST: begin
        // Even steps issue the reciprocal multiply, odd steps take its quotient digit.
        dstep_r <= dstep_r + 3'd1;
        if (dstep_r[0]) begin
          drem_r     <= dsr[9:0];
          dnum_r     <= {dnum_r[47:0], 16'b0};
          dist_mag_r <= {dist_mag_r[24:0], dsq};
        end
      end
      S_DIVW: begin
        if (div_done) begin
          case (div_idx_r)
            DIV_W:    w_q_r      <= div_quot[33:0];
            default:  ang_tc_r   <= diff_neg_r ? (~div_quot[47:0] + 48'd1) : div_quot[47:0];
          endcase
          div_idx_r <= div_idx_r + 2'd1;
        end
      end
      S_CORW: mstep_r <= MS_XL;
      S_MULB: begin
        mstep_r <= mstep_r + 4'd1;
        case (mstep_r)
          MS_XH:    accx_r <= mul_prod;
          MS_YL:    accx_r <= accx_r + {mul_prod[42:0], 21'b0};
          MS_YH:    accy_r <= mul_prod;
          MS_HL:    accy_r <= accy_r + {mul_prod[42:0], 21'b0};
          MS_HH:    acch_r <= mul_prod[47:0];
          MS_B_END: acch_r <= acch_r + {mul_prod[23:0], 24'b0};
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### tb/diff_drive_odometry_tb.sv
// Self-checking testbench for the differential-drive odometry block.
// Depends on ddo_pkg and diff_drive_odometry; predicts the results with its own pose integrator.
module diff_drive_odometry_tb;
  import ddo_pkg::*;

  localparam logic [1:0] REG_UNUSED   = 2'd3;
  localparam int         CYCLE_LIMIT  = 3000000;
  localparam int         PHASE_ITEMS  = 230;
  localparam int         NUM_PHASES   = 8;
  localparam int         DRAIN_CYCLES = 200;
  localparam longint unsigned INV_TURN = 64'd683565276;
  localparam longint     ROT_START    = 64'sd652032874;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;
  logic cfg_wr_en = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [15:0] cfg_wdata = '0;

  diff_drive_odometry dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Predictor copy of the registers and the pose.
  logic [15:0] m_radius;
  logic [15:0] m_separation;
  logic [9:0]  m_period;
  logic [31:0] m_x;
  logic [31:0] m_y;
  logic [15:0] m_heading;

  out_t pose_q[$];
  int   errors = 0;
  int   checked = 0;
  int   send_idle = 0;
  int   recv_idle = 0;
  int   cycles = 0;

  longint unsigned atan_rom[24] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
    64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
    64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
    64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
    64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051
  };

  function automatic longint round_div(longint num, longint unsigned den);
    longint unsigned mag;
    longint unsigned q;
    mag = (num < 0) ? longint'(-num) : num;
    q = (mag + den / 2) / den;
    return (num < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint clamp16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // Cosine and sine of a binary angle in Q2.16. Angles in the left half-plane
  // are turned by half a circle first and the results negated.
  function automatic void sin_cos(input logic [15:0] ang, output longint c, output longint s);
    logic [31:0] z;
    logic flip;
    longint x, y, zs, xs, ys;
    z = {ang, 16'h0};
    flip = (z[31:30] == 2'd1) || (z[31:30] == 2'd2);
    if (flip) z = z + 32'h80000000;
    zs = longint'($signed(z));
    x = ROT_START;
    y = 0;
    for (int i = 0; i < 16 && i < 24; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (zs >= 0) begin
        x = x - ys; y = y + xs; zs = zs - longint'(atan_rom[i]);
      end else begin
        x = x + ys; y = y - xs; zs = zs + longint'(atan_rom[i]);
      end
    end
    x = round_div(x, 64'd1 << 14);
    y = round_div(y, 64'd1 << 14);
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic out_t integrate_pose(in_t req);
    out_t res;
    longint wl, wr, r, p, pv, pw, step_len, ang, c, s, dx, dy;
    longint unsigned den, dh;
    wl = longint'(req.left_wheel_speed);
    wr = longint'(req.right_wheel_speed);
    r = longint'({48'd0, m_radius});
    p = longint'({54'd0, m_period});
    den = (m_separation == 16'd0) ? 64'd1 : {48'd0, m_separation};
    pv = r * (wl + wr);
    pw = r * (wr - wl);
    step_len = round_div(pv * p * 128, 64'd1000);
    ang = round_div(pw * p * 256, den * 64'd1000);
    sin_cos(m_heading, c, s);
    dx = round_div(step_len * c, 64'h1_0000_0000);
    dy = round_div(step_len * s, 64'h1_0000_0000);
    m_x = m_x + dx[31:0];
    m_y = m_y + dy[31:0];
    dh = ($unsigned(ang) * INV_TURN + 64'h80000000) >> 32;
    m_heading = m_heading + dh[15:0];
    res.linear_velocity = 16'(clamp16(round_div(pv, 64'd1 << 17)));
    res.angular_velocity = 16'(clamp16(round_div(pw, den)));
    res.position_x = m_x;
    res.position_y = m_y;
    res.heading_angle = m_heading;
    return res;
  endfunction

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      REG_WHEEL_RADIUS:     m_radius = val;
      REG_WHEEL_SEPARATION: m_separation = val;
      REG_PERIOD_MS:        m_period = val[9:0];
      default: ;
    endcase
  endtask

  // The request is taken at the first edge with valid high and stall low.
  task automatic send_req(in_t req, bit typed, out_t typed_res);
    out_t pred;
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (in_stall);
    pred = integrate_pose(req);
    pose_q.push_back(typed ? typed_res : pred);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pose_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic in_t rand_req();
    in_t q;
    int shape;
    shape = $urandom_range(3);
    q.left_wheel_speed = 16'($urandom);
    q.right_wheel_speed = 16'($urandom);
    if (shape == 1) begin
      q.left_wheel_speed = 16'($urandom_range(1024) - 512);
      q.right_wheel_speed = 16'($urandom_range(1024) - 512);
    end else if (shape == 2) begin
      q.right_wheel_speed = q.left_wheel_speed;
    end else if (shape == 3) begin
      q.right_wheel_speed = -q.left_wheel_speed;
    end
    return q;
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pose_q.size() == 0) begin
        $error("result with no request outstanding: %h", out_data);
        errors++;
      end else begin
        want = pose_q.pop_front();
        checked++;
        if (out_data.linear_velocity !== want.linear_velocity) begin
          $error("linear_velocity expected %0d got %0d", want.linear_velocity,
                 out_data.linear_velocity);
          errors++;
        end
        if (out_data.angular_velocity !== want.angular_velocity) begin
          $error("angular_velocity expected %0d got %0d", want.angular_velocity,
                 out_data.angular_velocity);
          errors++;
        end
        if (out_data.position_x !== want.position_x) begin
          $error("position_x expected %0d got %0d", want.position_x, out_data.position_x);
          errors++;
        end
        if (out_data.position_y !== want.position_y) begin
          $error("position_y expected %0d got %0d", want.position_y, out_data.position_y);
          errors++;
        end
        if (out_data.heading_angle !== want.heading_angle) begin
          $error("heading_angle expected %0d got %0d", want.heading_angle,
                 out_data.heading_angle);
          errors++;
        end
      end
    end
    out_stall <= ($urandom_range(99) < recv_idle);
  end

  typedef struct {
    logic signed [15:0] left;
    logic signed [15:0] right;
    bit                 typed;
  } row_t;

  // Only the first row has an obvious answer: from reset, standing still leaves all zero.
  row_t directed[18] = '{
    '{16'sd0, 16'sd0, 1'b1},
    '{16'sd256, 16'sd256, 1'b0},
    '{16'sd32767, 16'sd32767, 1'b0},
    '{-16'sd32768, -16'sd32768, 1'b0},
    '{16'sd32767, -16'sd32768, 1'b0},
    '{-16'sd32768, 16'sd32767, 1'b0},
    '{16'sd0, 16'sd12000, 1'b0},
    '{16'sd0, 16'sd12000, 1'b0},
    '{16'sd1000, 16'sd1000, 1'b0},
    '{16'sd12000, 16'sd0, 1'b0},
    '{16'sd1000, 16'sd1000, 1'b0},
    '{16'sd32767, 16'sd0, 1'b0},
    '{-16'sd1, 16'sd1, 1'b0},
    '{16'sd1, -16'sd1, 1'b0},
    '{16'sh5555, -16'sh5556, 1'b0},
    '{-16'sh5556, 16'sh5555, 1'b0},
    '{16'sd0, 16'sd0, 1'b0},
    '{16'sd300, 16'sd500, 1'b0}
  };

  initial begin
    in_t req;
    m_radius = RST_WHEEL_RADIUS;
    m_separation = RST_WHEEL_SEPARATION;
    m_period = RST_PERIOD_MS;
    m_x = '0;
    m_y = '0;
    m_heading = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph / 3)
        0: begin send_idle = 28; recv_idle = 46; end
        1: begin send_idle = 46; recv_idle = 28; end
        default: begin send_idle = 0; recv_idle = 0; end
      endcase
      case (ph)
        0: ;
        1: begin
          write_reg(REG_WHEEL_RADIUS, 16'd65535);
          write_reg(REG_WHEEL_SEPARATION, 16'd1);
          write_reg(REG_PERIOD_MS, 16'd1023);
        end
        2: begin
          write_reg(REG_WHEEL_RADIUS, 16'd1);
          write_reg(REG_WHEEL_SEPARATION, 16'd65535);
          write_reg(REG_PERIOD_MS, 16'd1);
        end
        3: begin
          // Zero separation acts as one; zero period means no motion.
          write_reg(REG_WHEEL_RADIUS, 16'd40000);
          write_reg(REG_WHEEL_SEPARATION, 16'd0);
          write_reg(REG_PERIOD_MS, 16'd0);
        end
        4: begin
          // Upper bits of the period write fall away; the unused index does nothing.
          write_reg(REG_PERIOD_MS, 16'hFFFF);
          write_reg(REG_WHEEL_SEPARATION, 16'd3000);
          write_reg(REG_UNUSED, 16'hFFFF);
        end
        default: begin
          write_reg(REG_WHEEL_RADIUS, 16'($urandom_range(65535, 1)));
          write_reg(REG_WHEEL_SEPARATION, 16'($urandom_range(65535, 1)));
          write_reg(REG_PERIOD_MS, 16'($urandom_range(1000, 1)));
        end
      endcase
      if (ph == 0) begin
        foreach (directed[k]) begin
          req.left_wheel_speed = directed[k].left;
          req.right_wheel_speed = directed[k].right;
          send_req(req, directed[k].typed, '0);
        end
      end
      for (int n = 0; n < PHASE_ITEMS; n++) send_req(rand_req(), 1'b0, '0);
      drain();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Checked %0d results over %0d register settings, including extremes,", checked,
             NUM_PHASES);
    $display("zero separation, zero period and masked period writes.");
    if (errors == 0 && pose_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### filelist.f
sv/ddo_pkg.sv
sv/ddo_mul.sv
sv/ddo_div.sv
sv/ddo_cordic.sv
sv/diff_drive_odometry.sv
tb/diff_drive_odometry_tb.sv
